/* hdl/lsra_pkg.sv */
// Shared constants and helper functions of the linear scan register allocator.
package lsra_pkg;

    localparam int OffsetBits = 20;
    localparam logic [OffsetBits-1:0] OffsetBase = 20'd16;
    localparam logic [OffsetBits-1:0] OffsetCap  = 20'hFFFF0;
    localparam logic [OffsetBits-1:0] GprSlot    = 20'd8;
    localparam logic [OffsetBits-1:0] VecSlot    = 20'd16;
    localparam int GprPoolLen = 17;
    localparam int VecPoolLen = 32;

    // Pool order: caller-saved first, then callee-saved.
    function automatic logic [4:0] pool_reg(input logic cls, input logic [4:0] idx);
        logic [4:0] r;
        begin
            r = 5'd0;
            if (cls)
            begin
                if (idx < 5'd8)
                    r = idx;
                else if (idx < 5'd24)
                    r = idx + 5'd8;
                else
                    r = idx - 5'd16;
            end
            else
            begin
                if (idx < 5'd7)
                    r = idx + 5'd9;
                else
                    r = idx + 5'd12;
            end
            return r;
        end
    endfunction

    function automatic logic is_callee(input logic cls, input logic [4:0] r);
        begin
            if (cls)
                return (r >= 5'd8) && (r <= 5'd15);
            return (r >= 5'd19) && (r <= 5'd28);
        end
    endfunction

endpackage

/* hdl/lsra_slot.sv */
// Spill slot offset counter with saturation.
module lsra_slot
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              take,
    input  logic                              cls,
    output logic [lsra_pkg::OffsetBits-1:0]   offset,
    output logic [lsra_pkg::OffsetBits-1:0]   offset_next_total
);
    logic [lsra_pkg::OffsetBits-1:0] offset_reg;
    logic [lsra_pkg::OffsetBits:0]   sum;
    logic [lsra_pkg::OffsetBits-1:0] offset_next;

    // Advance by slot size, saturate at the cap
    always_comb
    begin
        sum = {1'b0, offset_reg} + {1'b0, (cls ? lsra_pkg::VecSlot : lsra_pkg::GprSlot)};
        if (sum > {1'b0, lsra_pkg::OffsetCap})
            offset_next = lsra_pkg::OffsetCap;
        else
            offset_next = sum[lsra_pkg::OffsetBits-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            offset_reg <= lsra_pkg::OffsetBase;
        else if (take)
            offset_reg <= offset_next;
    end

    assign offset = offset_reg;
    // Total after this request, rounded up to 16
    always_comb
    begin
        if (take)
            offset_next_total = (offset_next + 20'd15) & ~20'd15;
        else
            offset_next_total = (offset_reg + 20'd15) & ~20'd15;
    end
endmodule

/* hdl/linear_scan_register_allocator_unit.sv */
// Top level of the linear scan register allocator.
// Usage: drive the interval fields and pulse start while busy is low; the
// request is taken at that edge and busy rises until the result is given.
// Each request then runs a small sequencer over the active table, one entry
// a cycle through a single compare unit:
//   pass 1: expire entries ending before the start, find the first free
//     entry and the furthest end / newest entry of the class;
//   pool search (no search when pinned);
//   pass 2 only when no register is free and the newest entry of the class
//     does not hold the furthest end;
//   the write state, then the done state that raises done.
// busy falls at the same edge as done rises, so the next request can be taken
// while done is high. done is high for one cycle with the result on the
// result ports; the receiver cannot stall it. Reset clears the valid bits,
// busy masks, insert counter and sets the spill offset to 16.
module linear_scan_register_allocator_unit
#(
    parameter int ACTIVE_DEPTH = 64,
    parameter int POINT_BITS   = 16,
    parameter int ID_BITS      = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    output logic        done,
    input  logic [15:0] interval_id,
    input  logic [15:0] interval_start,
    input  logic [15:0] interval_end,
    input  logic        vector_class,
    input  logic        pinned,
    input  logic [4:0]  pinned_reg,
    output logic        result_kind,
    output logic [4:0]  assigned_reg,
    output logic [19:0] slot_offset,
    output logic        callee_saved_used,
    output logic        victim_valid,
    output logic [15:0] victim_id,
    output logic [19:0] victim_offset,
    output logic [19:0] spill_total,
    output logic        table_overflow
);
    localparam int AW = (ACTIVE_DEPTH > 1) ? $clog2(ACTIVE_DEPTH) : 1;
    localparam logic [AW:0] LAST = (AW+1)'(ACTIVE_DEPTH - 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_POOL, S_SCAN2, S_WRITE, S_DONE} state_t;

    // Table memory
    logic [POINT_BITS-1:0] mem_end   [ACTIVE_DEPTH];
    logic [4:0]            mem_reg   [ACTIVE_DEPTH];
    logic                  mem_cls   [ACTIVE_DEPTH];
    logic [ID_BITS-1:0]    mem_ident [ACTIVE_DEPTH];
    logic [15:0]           mem_order [ACTIVE_DEPTH];
    logic [ACTIVE_DEPTH-1:0] valid_reg;

    state_t state_reg;
    logic [AW:0] idx_reg;
    logic [4:0]  pidx_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [POINT_BITS-1:0] st_reg, en_reg;
    logic cls_reg, pin_reg;
    logic [4:0] preg_reg;
    logic [15:0] icount_reg;
    logic [31:0] gmask_reg, vmask_reg;
    logic free_found_reg;
    logic [AW-1:0] free_idx_reg;
    logic any_reg, newest_has_reg;
    logic [POINT_BITS-1:0] best_end_reg, newest_end_reg;
    logic [15:0] newest_age_reg, first_age_reg;
    logic [AW-1:0] newest_reg, first_reg;
    logic [ID_BITS-1:0] newest_ident_reg, first_ident_reg;
    logic [4:0] newest_vreg_reg, first_vreg_reg;
    logic first_any_reg;
    logic reg_ok_reg;
    logic [4:0] areg_reg;

    // Registered read of the entry under the scan index
    logic [POINT_BITS-1:0] r_end;
    logic [4:0]  r_reg;
    logic        r_cls;
    logic [ID_BITS-1:0] r_ident;
    logic [15:0] r_order;
    logic        r_valid;
    logic [AW-1:0] r_idx;
    logic        r_live;

    // Result registers
    logic        kind_reg, callee_reg, vvalid_reg, ovf_reg, done_reg;
    logic [4:0]  out_reg_reg;
    logic [19:0] slot_reg, voff_reg, total_reg;
    logic [15:0] vid_reg;

    // Slot counter
    logic slot_take;
    logic [19:0] slot_at, slot_total;
    lsra_slot u_slot
    (
        .clk(clk), .rst_n(rst_n), .take(slot_take), .cls(cls_reg),
        .offset(slot_at), .offset_next_total(slot_total)
    );

    wire [AW-1:0] idx = idx_reg[AW-1:0];
    wire [31:0] cmask = cls_reg ? vmask_reg : gmask_reg;
    wire [4:0]  cand = lsra_pkg::pool_reg(cls_reg, pidx_reg);
    wire [4:0]  plen = cls_reg ? 5'd31 : 5'd16;
    wire [15:0] r_age = icount_reg - r_order;
    wire same = r_live && r_valid && (r_cls == cls_reg);
    wire expire = r_live && r_valid && (r_end < st_reg);

    // Decision made at the write step
    logic do_victim;
    logic [AW-1:0] vic_idx;
    logic [4:0] vic_reg;
    logic [ID_BITS-1:0] vic_ident;
    always_comb
    begin
        vic_idx = newest_has_reg ? newest_reg : first_reg;
        vic_reg = newest_has_reg ? newest_vreg_reg : first_vreg_reg;
        vic_ident = newest_has_reg ? newest_ident_reg : first_ident_reg;
        do_victim = any_reg && !reg_ok_reg && (best_end_reg > en_reg);
    end
    assign slot_take = (state_reg == S_WRITE) &&
                       ((reg_ok_reg && !free_found_reg) || !reg_ok_reg);

    // Memory reads and writes
    always_ff @(posedge clk)
    begin
        r_end   <= mem_end[idx];
        r_reg   <= mem_reg[idx];
        r_cls   <= mem_cls[idx];
        r_ident <= mem_ident[idx];
        r_order <= mem_order[idx];
        r_idx   <= idx;
        if (state_reg == S_WRITE && ((reg_ok_reg && free_found_reg) || do_victim))
        begin
            mem_end[reg_ok_reg ? free_idx_reg : vic_idx]   <= en_reg;
            mem_reg[reg_ok_reg ? free_idx_reg : vic_idx]   <= reg_ok_reg ? areg_reg : vic_reg;
            mem_cls[reg_ok_reg ? free_idx_reg : vic_idx]   <= cls_reg;
            mem_ident[reg_ok_reg ? free_idx_reg : vic_idx] <= id_reg;
            mem_order[reg_ok_reg ? free_idx_reg : vic_idx] <= icount_reg;
        end
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE; idx_reg <= '0; pidx_reg <= '0;
            valid_reg <= '0; icount_reg <= '0; gmask_reg <= '0; vmask_reg <= '0;
            r_live <= 1'b0; r_valid <= 1'b0; done_reg <= 1'b0;
            id_reg <= '0; st_reg <= '0; en_reg <= '0; cls_reg <= 1'b0; pin_reg <= 1'b0;
            preg_reg <= '0; free_found_reg <= 1'b0; free_idx_reg <= '0;
            any_reg <= 1'b0; newest_has_reg <= 1'b0; best_end_reg <= '0;
            newest_end_reg <= '0; newest_age_reg <= '0; first_age_reg <= '0;
            newest_reg <= '0; first_reg <= '0; first_any_reg <= 1'b0;
            newest_ident_reg <= '0; first_ident_reg <= '0;
            newest_vreg_reg <= '0; first_vreg_reg <= '0;
            reg_ok_reg <= 1'b0; areg_reg <= '0;
            kind_reg <= 1'b0; callee_reg <= 1'b0; vvalid_reg <= 1'b0; ovf_reg <= 1'b0;
            out_reg_reg <= '0; slot_reg <= '0; voff_reg <= '0; total_reg <= '0;
            vid_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            r_valid <= valid_reg[idx];
            unique case (state_reg)
                S_IDLE:
                begin
                    r_live <= 1'b0;
                    if (start)
                    begin
                        id_reg <= ID_BITS'(interval_id);
                        st_reg <= POINT_BITS'(interval_start);
                        en_reg <= POINT_BITS'(interval_end);
                        cls_reg <= vector_class; pin_reg <= pinned; preg_reg <= pinned_reg;
                        idx_reg <= '0; pidx_reg <= '0;
                        free_found_reg <= 1'b0; any_reg <= 1'b0; first_any_reg <= 1'b0;
                        state_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    // Issue reads; process the entry read last cycle
                    r_live <= (idx_reg <= LAST);
                    if (idx_reg <= LAST)
                        idx_reg <= idx_reg + 1'b1;
                    if (expire)
                    begin
                        valid_reg[r_idx] <= 1'b0;
                        if (r_cls)
                            vmask_reg[r_reg] <= 1'b0;
                        else
                            gmask_reg[r_reg] <= 1'b0;
                        if (!free_found_reg)
                        begin
                            free_found_reg <= 1'b1; free_idx_reg <= r_idx;
                        end
                    end
                    else if (r_live && !r_valid && !free_found_reg)
                    begin
                        free_found_reg <= 1'b1; free_idx_reg <= r_idx;
                    end
                    if (same && !expire)
                    begin
                        if (!any_reg || r_end > best_end_reg)
                            best_end_reg <= r_end;
                        any_reg <= 1'b1;
                        if (!any_reg || r_age < newest_age_reg)
                        begin
                            newest_reg <= r_idx; newest_age_reg <= r_age;
                            newest_end_reg <= r_end;
                            newest_ident_reg <= r_ident; newest_vreg_reg <= r_reg;
                        end
                    end
                    if (!r_live && idx_reg > LAST)
                    begin
                        state_reg <= S_POOL;
                        reg_ok_reg <= pin_reg;
                        areg_reg <= preg_reg;
                    end
                end
                S_POOL:
                begin
                    newest_has_reg <= newest_end_reg == best_end_reg;
                    if (pin_reg)
                        state_reg <= S_WRITE;
                    else if (!cmask[cand])
                    begin
                        reg_ok_reg <= 1'b1; areg_reg <= cand; state_reg <= S_WRITE;
                    end
                    else if (pidx_reg == plen)
                    begin
                        idx_reg <= '0; r_live <= 1'b0;
                        state_reg <= (any_reg && newest_end_reg != best_end_reg)
                                     ? S_SCAN2 : S_WRITE;
                    end
                    else
                        pidx_reg <= pidx_reg + 1'b1;
                end
                S_SCAN2:
                begin
                    r_live <= (idx_reg <= LAST);
                    if (idx_reg <= LAST)
                        idx_reg <= idx_reg + 1'b1;
                    if (same && r_end == best_end_reg &&
                        (!first_any_reg || r_age > first_age_reg))
                    begin
                        first_any_reg <= 1'b1; first_reg <= r_idx; first_age_reg <= r_age;
                        first_ident_reg <= r_ident; first_vreg_reg <= r_reg;
                    end
                    if (!r_live && idx_reg > LAST)
                        state_reg <= S_WRITE;
                end
                S_WRITE:
                begin
                    kind_reg <= 1'b0; callee_reg <= 1'b0; vvalid_reg <= 1'b0;
                    ovf_reg <= 1'b0; out_reg_reg <= '0; slot_reg <= '0;
                    voff_reg <= '0; vid_reg <= '0;
                    if (reg_ok_reg)
                    begin
                        if (free_found_reg)
                        begin
                            valid_reg[free_idx_reg] <= 1'b1;
                            icount_reg <= icount_reg + 1'b1;
                            if (cls_reg)
                                vmask_reg[areg_reg] <= 1'b1;
                            else
                                gmask_reg[areg_reg] <= 1'b1;
                            out_reg_reg <= areg_reg;
                            callee_reg <= !pin_reg && lsra_pkg::is_callee(cls_reg, areg_reg);
                        end
                        else
                        begin
                            kind_reg <= 1'b1; slot_reg <= slot_at; ovf_reg <= 1'b1;
                        end
                    end
                    else if (do_victim)
                    begin
                        vvalid_reg <= 1'b1;
                        vid_reg <= 16'(vic_ident);
                        voff_reg <= slot_at;
                        out_reg_reg <= vic_reg;
                        icount_reg <= icount_reg + 1'b1;
                    end
                    else
                    begin
                        kind_reg <= 1'b1; slot_reg <= slot_at;
                    end
                    total_reg <= slot_total;
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    done_reg <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result_kind = kind_reg;
    assign assigned_reg = out_reg_reg;
    assign slot_offset = slot_reg;
    assign callee_saved_used = callee_reg;
    assign victim_valid = vvalid_reg;
    assign victim_id = vid_reg;
    assign victim_offset = voff_reg;
    assign spill_total = total_reg;
    assign table_overflow = ovf_reg;
endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the linear scan register allocator unit.
module tb;

    localparam int TableDepth = 64;
    localparam int CycleLimit = 2000000;
    localparam int MaxReports = 10;

    typedef enum logic { KIND_REG = 1'b0, KIND_SPILL = 1'b1 } kind_e;

    typedef struct packed {
        logic        kind;
        logic [4:0]  reg_no;
        logic [19:0] slot;
        logic        callee;
        logic        vic_valid;
        logic [15:0] vic_id;
        logic [19:0] vic_slot;
        logic [19:0] total;
        logic        overflow;
    } alloc_t;

    // Allocation predictor and queue of pending allocation results
    class alloc_board;
        logic        live [TableDepth];
        logic [15:0] live_end [TableDepth];
        logic [4:0]  live_reg [TableDepth];
        logic        live_vec [TableDepth];
        logic [15:0] live_id [TableDepth];
        logic [15:0] live_seq [TableDepth];
        logic [15:0] seq_count;
        logic [31:0] gpr_busy;
        logic [31:0] vec_busy;
        logic [19:0] offset;
        logic [4:0]  gpr_order [17];
        logic [4:0]  vec_order [32];
        alloc_t      pending [$];
        int          errors;

        function new();
            for (int i = 0; i < 7; i++) gpr_order[i] = 5'(9 + i);
            for (int i = 0; i < 10; i++) gpr_order[7 + i] = 5'(19 + i);
            for (int i = 0; i < 8; i++) vec_order[i] = 5'(i);
            for (int i = 0; i < 16; i++) vec_order[8 + i] = 5'(16 + i);
            for (int i = 0; i < 8; i++) vec_order[24 + i] = 5'(8 + i);
            for (int k = 0; k < TableDepth; k++) live[k] = 1'b0;
            seq_count = '0;
            gpr_busy = '0;
            vec_busy = '0;
            offset = lsra_pkg::OffsetBase;
            errors = 0;
        endfunction

        function logic [19:0] grab_slot(input logic vec);
            logic [20:0] nxt;
            logic [19:0] at;
            at = offset;
            nxt = {1'b0, offset} + (vec ? 21'd16 : 21'd8);
            if (nxt > {1'b0, lsra_pkg::OffsetCap})
                nxt = {1'b0, lsra_pkg::OffsetCap};
            offset = nxt[19:0];
            return at;
        endfunction

        function void enter(input int k, input logic [15:0] e, input logic [4:0] r,
                            input logic vec, input logic [15:0] id);
            live[k] = 1'b1;
            live_end[k] = e;
            live_reg[k] = r;
            live_vec[k] = vec;
            live_id[k] = id;
            live_seq[k] = seq_count;
            seq_count = seq_count + 16'd1;
        endfunction

        // Predict the result of one accepted request
        function void note(input logic [15:0] id, input logic [15:0] s,
                           input logic [15:0] e, input logic vec, input logic pin,
                           input logic [4:0] preg);
            alloc_t x;
            int r, slot_k, newest, first, victim;
            logic [15:0] newest_age, first_age, best_end, age;
            logic [31:0] mask;
            logic any;
            x = '0;
            // drop every entry that ends before the new start
            for (int k = 0; k < TableDepth; k++)
                if (live[k] && live_end[k] < s)
                begin
                    if (live_vec[k])
                        vec_busy[live_reg[k]] = 1'b0;
                    else
                        gpr_busy[live_reg[k]] = 1'b0;
                    live[k] = 1'b0;
                end
            mask = vec ? vec_busy : gpr_busy;
            r = -1;
            if (pin)
                r = preg;
            else
                for (int i = 0; i < (vec ? 32 : 17) && r < 0; i++)
                begin
                    if (vec && !mask[vec_order[i]]) r = vec_order[i];
                    if (!vec && !mask[gpr_order[i]]) r = gpr_order[i];
                end
            if (r >= 0)
            begin
                slot_k = -1;
                for (int k = 0; k < TableDepth && slot_k < 0; k++)
                    if (!live[k]) slot_k = k;
                if (slot_k < 0)
                begin
                    x.kind = KIND_SPILL;
                    x.slot = grab_slot(vec);
                    x.overflow = 1'b1;
                end
                else
                begin
                    enter(slot_k, e, 5'(r), vec, id);
                    if (vec) vec_busy[r] = 1'b1;
                    else gpr_busy[r] = 1'b1;
                    x.reg_no = 5'(r);
                    if (!pin)
                        x.callee = vec ? (r >= 8 && r <= 15) : (r >= 19 && r <= 28);
                end
            end
            else
            begin
                newest = -1;
                first = -1;
                newest_age = '0;
                first_age = '0;
                best_end = '0;
                any = 1'b0;
                for (int k = 0; k < TableDepth; k++)
                    if (live[k] && live_vec[k] == vec)
                    begin
                        age = seq_count - live_seq[k];
                        if (!any || live_end[k] > best_end) best_end = live_end[k];
                        any = 1'b1;
                        if (newest < 0 || age < newest_age)
                        begin
                            newest = k;
                            newest_age = age;
                        end
                    end
                for (int k = 0; k < TableDepth; k++)
                    if (live[k] && live_vec[k] == vec && live_end[k] == best_end)
                    begin
                        age = seq_count - live_seq[k];
                        if (first < 0 || age > first_age)
                        begin
                            first = k;
                            first_age = age;
                        end
                    end
                victim = -1;
                if (any)
                    victim = (live_end[newest] == best_end) ? newest : first;
                if (victim >= 0 && live_end[victim] > e)
                begin
                    x.vic_valid = 1'b1;
                    x.vic_id = live_id[victim];
                    x.vic_slot = grab_slot(vec);
                    x.reg_no = live_reg[victim];
                    enter(victim, e, live_reg[victim], vec, id);
                end
                else
                begin
                    x.kind = KIND_SPILL;
                    x.slot = grab_slot(vec);
                end
            end
            x.total = (offset + 20'd15) & ~20'd15;
            pending = {pending, x};
        endfunction

        // Compare one result with the oldest prediction
        function void check(input alloc_t got);
            alloc_t want;
            if (pending.size() == 0)
            begin
                errors++;
                if (errors <= MaxReports)
                    $display("unexpected result %h", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want)
            begin
                errors++;
                if (errors <= MaxReports)
                begin
                    $display("mismatch: expected kind=%0d reg=%0d slot=%h callee=%0d vv=%0d",
                             want.kind, want.reg_no, want.slot, want.callee, want.vic_valid,
                             " vid=%h vslot=%h total=%h ovf=%0d",
                             want.vic_id, want.vic_slot, want.total, want.overflow);
                    $display("          got kind=%0d reg=%0d slot=%h callee=%0d vv=%0d",
                             got.kind, got.reg_no, got.slot, got.callee, got.vic_valid,
                             " vid=%h vslot=%h total=%h ovf=%0d",
                             got.vic_id, got.vic_slot, got.total, got.overflow);
                end
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic        done;
    logic [15:0] interval_id;
    logic [15:0] interval_start;
    logic [15:0] interval_end;
    logic        vector_class;
    logic        pinned;
    logic [4:0]  pinned_reg;
    logic        result_kind;
    logic [4:0]  assigned_reg;
    logic [19:0] slot_offset;
    logic        callee_saved_used;
    logic        victim_valid;
    logic [15:0] victim_id;
    logic [19:0] victim_offset;
    logic [19:0] spill_total;
    logic        table_overflow;

    alloc_board board;
    int         cycles = 0;
    logic       no_gaps;

    linear_scan_register_allocator_unit dut (
        .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .done(done),
        .interval_id(interval_id), .interval_start(interval_start),
        .interval_end(interval_end), .vector_class(vector_class), .pinned(pinned),
        .pinned_reg(pinned_reg), .result_kind(result_kind),
        .assigned_reg(assigned_reg), .slot_offset(slot_offset),
        .callee_saved_used(callee_saved_used), .victim_valid(victim_valid),
        .victim_id(victim_id), .victim_offset(victim_offset),
        .spill_total(spill_total), .table_overflow(table_overflow)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Check each result while it is held stable
    always @(negedge clk)
        if (rst_n && done === 1'b1)
            board.check({result_kind, assigned_reg, slot_offset, callee_saved_used,
                         victim_valid, victim_id, victim_offset, spill_total,
                         table_overflow});

    // Present one request and hold it until taken
    task automatic send(input logic [15:0] id, input logic [15:0] s, input logic [15:0] e,
                        input logic vec, input logic pin, input logic [4:0] preg);
        int gap;
        gap = no_gaps ? 0 : $urandom_range(0, 6);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        interval_id <= id;
        interval_start <= s;
        interval_end <= e;
        vector_class <= vec;
        pinned <= pin;
        pinned_reg <= preg;
        start <= 1'b1;
        do @(negedge clk); while (busy !== 1'b0);
        board.note(id, s, e, vec, pin, preg);
        @(posedge clk);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (board.pending.size() != 0) @(posedge clk);
    endtask

    initial
    begin
        int cursor, span, kind, sent;
        logic [15:0] s, e;
        board = new();
        no_gaps = 1'b0;
        rst_n = 1'b0;
        start = 1'b0;
        interval_id = '0;
        interval_start = '0;
        interval_end = '0;
        vector_class = 1'b0;
        pinned = 1'b0;
        pinned_reg = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, pins, both classes, end before start
        send(16'h0000, 16'd0, 16'hFFFF, 1'b0, 1'b1, 5'd0);
        send(16'hFFFF, 16'd0, 16'hFFFF, 1'b1, 1'b1, 5'd31);
        send(16'h1234, 16'd1, 16'd1, 1'b0, 1'b1, 5'd0);
        send(16'h0001, 16'd2, 16'd100, 1'b0, 1'b0, 5'd0);
        send(16'h0002, 16'd2, 16'd100, 1'b1, 1'b0, 5'd0);
        send(16'h0003, 16'd10, 16'd5, 1'b0, 1'b0, 5'd0);
        send(16'h0004, 16'd11, 16'd50, 1'b0, 1'b0, 5'd0);
        for (int i = 0; i < 16; i++)
            send(16'(16'h100 + i), 16'd12, 16'(200 + (i % 3) * 100), 1'b0, 1'b0, 5'd0);
        send(16'h0200, 16'd13, 16'd250, 1'b0, 1'b0, 5'd0);
        send(16'h0201, 16'd13, 16'd40, 1'b0, 1'b0, 5'd0);
        send(16'h0202, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 5'd0);
        drain();
        // hold off until every result is in
        repeat (200) @(posedge clk);

        // random phases of sorted intervals with occasional noise
        sent = 0;
        cursor = 0;
        while (sent < 1250)
        begin
            kind = $urandom_range(0, 4);
            span = (kind == 0) ? 20 : (kind == 1) ? 3000 : 400;
            no_gaps = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 2) == 0 || cursor > 60000)
                cursor = $urandom_range(0, 50000);
            for (int j = 0; j < 40; j++)
            begin
                s = 16'(cursor);
                if (kind == 3)
                    e = 16'(cursor + 500 + 50 * $urandom_range(0, 2));
                else
                    e = (cursor + span > 65535) ? 16'hFFFF :
                        16'(cursor + $urandom_range(0, span));
                if ($urandom_range(0, 19) == 0)
                    send(16'($urandom), 16'($urandom), 16'($urandom), 1'($urandom),
                         1'($urandom), 5'($urandom));
                else
                    send(16'($urandom), s, e, 1'($urandom),
                         (kind == 4) ? ($urandom_range(0, 7) != 0)
                                     : ($urandom_range(0, 7) == 0),
                         5'($urandom));
                cursor = cursor + $urandom_range(0, 3);
                sent++;
            end
        end
        drain();
        repeat (300) @(posedge clk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
